// ===== design/formula_charge_element_parser_defines.svh =====
// Assertion macros for the verification file of the formula parser.
// Depends on nothing; included by the checker module.
`ifndef FORMULA_CHARGE_ELEMENT_PARSER_DEFINES_SVH
`define FORMULA_CHARGE_ELEMENT_PARSER_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define FCEP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fcep assertion failed");

// Next-cycle implication, disabled during reset
`define FCEP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fcep assertion failed");

`endif

// ===== design/fcep_pkg.sv =====
// Shared types and character constants for the formula charge/element parser.
// Depends on nothing; used by fcep_step, the top level and the checker.
`timescale 1ns / 1ps

package fcep_pkg;

    // Parse phase, one-hot
    typedef enum logic [4:0] {
        PH_EXPECT = 5'b00001,
        PH_SYMBOL = 5'b00010,
        PH_COEFF  = 5'b00100,
        PH_SIGN   = 5'b01000,
        PH_CHARGE = 5'b10000
    } phase_t;

    // Control part of the parser state
    typedef struct packed {
        phase_t phase;
        logic   neg;
        logic   err;
    } ctl_t;

    localparam ctl_t CTL_RESET = '{phase: PH_EXPECT, neg: 1'b0, err: 1'b0};

    localparam logic [7:0] CHAR_END   = 8'h00;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_UA    = 8'h41;
    localparam logic [7:0] CHAR_UZ    = 8'h5A;
    localparam logic [7:0] CHAR_LA    = 8'h61;
    localparam logic [7:0] CHAR_LE    = 8'h65;
    localparam logic [7:0] CHAR_LZ    = 8'h7A;

endpackage

// ===== design/fcep_step.sv =====
// Next-state and result logic for one formula character.
// Depends on fcep_pkg; instanced by formula_charge_element_parser.
`timescale 1ns / 1ps

module fcep_step #(
    parameter int CHARGE_BITS = 16,
    parameter int COUNT_BITS  = 8
) (
    input  logic [7:0]                    code,
    input  fcep_pkg::ctl_t                ctl,
    input  logic signed [CHARGE_BITS-1:0] sum,
    input  logic [CHARGE_BITS-1:0]        mag,
    input  logic [COUNT_BITS-1:0]         count,
    output fcep_pkg::ctl_t                ctl_next,
    output logic signed [CHARGE_BITS-1:0] sum_next,
    output logic [CHARGE_BITS-1:0]        mag_next,
    output logic [COUNT_BITS-1:0]         count_next,
    output logic                          emit,
    output logic signed [CHARGE_BITS-1:0] res_charge,
    output logic [COUNT_BITS-1:0]         res_count,
    output logic                          res_error
);

    localparam int MW = CHARGE_BITS + 4;
    localparam int SW = CHARGE_BITS + 2;
    localparam logic [MW-1:0] MAG_LIMIT = MW'(1) << (CHARGE_BITS - 1);
    localparam logic signed [SW-1:0] SUM_HI = {3'b000, {(CHARGE_BITS-1){1'b1}}};
    localparam logic signed [SW-1:0] SUM_LO = {3'b111, {(CHARGE_BITS-1){1'b0}}};
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    logic is_end, is_space, is_lower, is_upper, is_digit, is_sign;
    logic [3:0] digit;
    logic [MW-1:0] mag_wide;
    logic [CHARGE_BITS-1:0] mag_acc;
    logic flush;
    logic [CHARGE_BITS-1:0] flush_mag;
    logic signed [SW-1:0] sum_ext, mag_ext, sum_raw, sum_sat;
    logic do_begin;
    logic [COUNT_BITS-1:0] count_final;
    fcep_pkg::ctl_t ctl_work;
    logic [COUNT_BITS-1:0] count_work;
    logic [CHARGE_BITS-1:0] mag_work;

    // Character classes
    always_comb
    begin
        is_end   = (code == fcep_pkg::CHAR_END);
        is_space = (code == fcep_pkg::CHAR_SPACE) ||
                   (code >= fcep_pkg::CHAR_TAB && code <= fcep_pkg::CHAR_CR);
        is_lower = (code >= fcep_pkg::CHAR_LA) && (code <= fcep_pkg::CHAR_LZ);
        is_upper = (code >= fcep_pkg::CHAR_UA) && (code <= fcep_pkg::CHAR_UZ);
        is_digit = (code >= fcep_pkg::CHAR_ZERO) && (code <= fcep_pkg::CHAR_NINE);
        is_sign  = (code == fcep_pkg::CHAR_PLUS) || (code == fcep_pkg::CHAR_MINUS);
        digit    = 4'(code - fcep_pkg::CHAR_ZERO);
    end

    // Charge digit accumulate: mag * 10 + digit, saturating
    always_comb
    begin
        mag_wide = ({4'b0000, mag} << 3) + ({4'b0000, mag} << 1) + MW'(digit);
        mag_acc  = (mag_wide > MAG_LIMIT) ? MAG_LIMIT[CHARGE_BITS-1:0]
                                          : mag_wide[CHARGE_BITS-1:0];
    end

    // Phase machine
    always_comb
    begin
        ctl_work   = ctl;
        mag_work   = mag;
        count_work = count;
        flush      = 1'b0;
        do_begin   = 1'b0;
        if (!ctl.err && !is_end)
        begin
            case (ctl.phase)
                fcep_pkg::PH_SYMBOL,
                fcep_pkg::PH_COEFF:
                begin
                    if (ctl.phase == fcep_pkg::PH_SYMBOL && is_lower)
                    begin
                        ctl_work.phase = fcep_pkg::PH_SYMBOL;
                    end
                    else if (is_digit)
                    begin
                        ctl_work.phase = fcep_pkg::PH_COEFF;
                    end
                    else if (is_sign)
                    begin
                        ctl_work.neg   = (code == fcep_pkg::CHAR_MINUS);
                        ctl_work.phase = fcep_pkg::PH_SIGN;
                    end
                    else
                    begin
                        do_begin = 1'b1;
                    end
                end
                fcep_pkg::PH_SIGN:
                begin
                    if (is_digit)
                    begin
                        mag_work       = CHARGE_BITS'(digit);
                        ctl_work.phase = fcep_pkg::PH_CHARGE;
                    end
                    else
                    begin
                        flush    = 1'b1;
                        do_begin = 1'b1;
                    end
                end
                fcep_pkg::PH_CHARGE:
                begin
                    if (is_digit)
                    begin
                        mag_work = mag_acc;
                    end
                    else
                    begin
                        flush    = 1'b1;
                        do_begin = 1'b1;
                    end
                end
                default:
                begin
                    do_begin = 1'b1;
                end
            endcase

            // Start of a new item
            if (do_begin)
            begin
                if (is_space)
                begin
                    ctl_work.phase = fcep_pkg::PH_EXPECT;
                end
                else if (code == fcep_pkg::CHAR_LE)
                begin
                    ctl_work.phase = fcep_pkg::PH_COEFF;
                end
                else if (is_lower || is_upper)
                begin
                    if (count != COUNT_MAX)
                        count_work = count + COUNT_BITS'(1);
                    ctl_work.phase = fcep_pkg::PH_SYMBOL;
                end
                else
                begin
                    ctl_work.err   = 1'b1;
                    ctl_work.phase = fcep_pkg::PH_EXPECT;
                end
            end
        end
        else if (!ctl.err && is_end)
        begin
            flush = (ctl.phase == fcep_pkg::PH_SIGN) || (ctl.phase == fcep_pkg::PH_CHARGE);
        end
    end

    // Saturating charge add
    always_comb
    begin
        flush_mag = (ctl.phase == fcep_pkg::PH_SIGN) ? CHARGE_BITS'(1) : mag;
        sum_ext   = {{2{sum[CHARGE_BITS-1]}}, sum};
        mag_ext   = {2'b00, flush_mag};
        sum_raw   = ctl.neg ? (sum_ext - mag_ext) : (sum_ext + mag_ext);
        if (sum_raw > SUM_HI)
            sum_sat = SUM_HI;
        else if (sum_raw < SUM_LO)
            sum_sat = SUM_LO;
        else
            sum_sat = sum_raw;
    end

    // Result on the end character, then back to reset
    always_comb
    begin
        sum_next    = flush ? sum_sat[CHARGE_BITS-1:0] : sum;
        count_final = count;
        if (sum_next != '0 && count != COUNT_MAX)
            count_final = count + COUNT_BITS'(1);
        emit       = is_end;
        res_error  = ctl.err;
        res_charge = ctl.err ? '0 : sum_next;
        res_count  = ctl.err ? '0 : count_final;
        if (is_end)
        begin
            ctl_next   = fcep_pkg::CTL_RESET;
            sum_next   = '0;
            mag_next   = '0;
            count_next = '0;
        end
        else
        begin
            ctl_next   = ctl_work;
            mag_next   = mag_work;
            count_next = count_work;
        end
    end

endmodule

// ===== design/formula_charge_element_parser.sv =====
// An end character passes through the input register, then its result through the result
// register; a stalled result keeps the end character waiting in the input register.
// Throughput: one character per cycle; a stalled result holds only an end character
// in the input register, other characters keep flowing.
// Reset (rst_n low, asynchronous): parser back to expect-symbol, no item held.
`timescale 1ns / 1ps

module formula_charge_element_parser #(
    parameter int CHARGE_BITS = 16,
    parameter int COUNT_BITS  = 8
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          char_valid,
    output logic                          char_ready,
    input  logic [7:0]                    char_code,
    output logic                          result_valid,
    input  logic                          result_ready,
    output logic signed [CHARGE_BITS-1:0] total_charge,
    output logic [COUNT_BITS-1:0]         element_count,
    output logic                          parse_error
);

    logic                          stage_valid_reg;
    logic [7:0]                    stage_char_reg;
    fcep_pkg::ctl_t                ctl_reg, ctl_next;
    logic signed [CHARGE_BITS-1:0] sum_reg, sum_next;
    logic [CHARGE_BITS-1:0]        mag_reg, mag_next;
    logic [COUNT_BITS-1:0]         count_reg, count_next;
    logic                          emit;
    logic signed [CHARGE_BITS-1:0] res_charge;
    logic [COUNT_BITS-1:0]         res_count;
    logic                          res_error;
    logic                          out_free, advance;

    fcep_step #(
        .CHARGE_BITS(CHARGE_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_step (
        .code      (stage_char_reg),
        .ctl       (ctl_reg),
        .sum       (sum_reg),
        .mag       (mag_reg),
        .count     (count_reg),
        .ctl_next  (ctl_next),
        .sum_next  (sum_next),
        .mag_next  (mag_next),
        .count_next(count_next),
        .emit      (emit),
        .res_charge(res_charge),
        .res_count (res_count),
        .res_error (res_error)
    );

    // Handshake: an end item waits only for a free result slot
    assign out_free   = !result_valid || result_ready;
    assign advance    = stage_valid_reg && (!emit || out_free);
    assign char_ready = !stage_valid_reg || advance;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            stage_valid_reg <= 1'b0;
        else if (char_ready)
            stage_valid_reg <= char_valid;
    end

    always_ff @(posedge clk)
    begin
        if (char_ready && char_valid)
            stage_char_reg <= char_code;
    end

    // Parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg   <= fcep_pkg::CTL_RESET;
            sum_reg   <= '0;
            mag_reg   <= '0;
            count_reg <= '0;
        end
        else if (advance)
        begin
            ctl_reg   <= ctl_next;
            sum_reg   <= sum_next;
            mag_reg   <= mag_next;
            count_reg <= count_next;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_valid <= 1'b0;
        else if (advance && emit)
            result_valid <= 1'b1;
        else if (result_ready)
            result_valid <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance && emit)
        begin
            total_charge  <= res_charge;
            element_count <= res_count;
            parse_error   <= res_error;
        end
    end

endmodule

// ===== design/fcep_checker.sv =====
// Port-level checks for the formula parser, bound to the top level.
// Depends on fcep_pkg and formula_charge_element_parser_defines.svh.
`timescale 1ns / 1ps
`include "formula_charge_element_parser_defines.svh"

module fcep_checker #(
    parameter int CHARGE_BITS = 16,
    parameter int COUNT_BITS  = 8
) (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          char_valid,
    input logic                          char_ready,
    input logic [7:0]                    char_code,
    input logic                          result_valid,
    input logic                          result_ready,
    input logic signed [CHARGE_BITS-1:0] total_charge,
    input logic [COUNT_BITS-1:0]         element_count,
    input logic                          parse_error
);

    // A stalled result holds its fields
    `FCEP_ASSERT_NEXT(a_result_hold, clk, rst_n, result_valid && !result_ready, result_valid && $stable(total_charge) && $stable(element_count) && $stable(parse_error))

    // An error result carries zero values
    `FCEP_ASSERT_NOW(a_error_zero, clk, rst_n, result_valid && parse_error, total_charge == '0 && element_count == '0)

    // A charged result counts at least the extra element
    `FCEP_ASSERT_NOW(a_charge_counts, clk, rst_n, result_valid && !parse_error && total_charge != '0, element_count != '0)

    // A fresh result follows an accepted end item through the input and result registers
    `FCEP_ASSERT_NOW(a_result_origin, clk, rst_n, $rose(result_valid), $past(char_valid && char_ready && char_code == fcep_pkg::CHAR_END, 2))

endmodule

bind formula_charge_element_parser fcep_checker #(
    .CHARGE_BITS(CHARGE_BITS),
    .COUNT_BITS (COUNT_BITS)
) u_fcep_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .char_valid   (char_valid),
    .char_ready   (char_ready),
    .char_code    (char_code),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .total_charge (total_charge),
    .element_count(element_count),
    .parse_error  (parse_error)
);
